@@ sv/pgpb_pkg.sv @@
package pgpb_pkg;

	localparam int ANG_BITS     = 20;
	localparam int CORDIC_STEPS = 18;
	localparam int SQRT_STEPS   = 20;
	localparam int DIV_STEPS    = 20;
	localparam int NUM_STAGES   = SQRT_STEPS + DIV_STEPS;
	localparam int SECTOR_STAGE = CORDIC_STEPS;
	localparam int MAX_SECTORS  = 256;
	localparam int MAX_RINGS    = 256;
	localparam int FIFO_DEPTH   = 4;

	localparam logic [1:0] REG_NUM_SECTORS  = 2'd0;
	localparam logic [1:0] REG_NUM_RINGS    = 2'd1;
	localparam logic [1:0] REG_RING_SPACING = 2'd2;

	typedef struct packed {
		logic [8:0]  num_sectors;
		logic [8:0]  num_rings;
		logic [15:0] ring_spacing;
	} cfg_t;

	typedef struct packed {
		logic signed [20:0] x;
		logic signed [20:0] y;
		logic               axis;
		logic signed [20:0] base;
		logic [39:0]        r2;
		logic [17:0]        tag;
	} pt_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [21:0] z;
		logic signed [20:0] base;
		logic               axis;
		logic [8:0]         sec;
		logic [39:0]        n;
		logic [39:0]        r;
		logic [15:0]        rem;
		logic [19:0]        q;
		logic [17:0]        tag;
	} st_t;

	function automatic logic signed [21:0] atan_entry(input int i);
		logic signed [21:0] v;
		case (i)
			0:  v = 22'sd131072;
			1:  v = 22'sd77376;
			2:  v = 22'sd40884;
			3:  v = 22'sd20753;
			4:  v = 22'sd10417;
			5:  v = 22'sd5213;
			6:  v = 22'sd2607;
			7:  v = 22'sd1304;
			8:  v = 22'sd652;
			9:  v = 22'sd326;
			10: v = 22'sd163;
			11: v = 22'sd81;
			12: v = 22'sd41;
			13: v = 22'sd20;
			14: v = 22'sd10;
			15: v = 22'sd5;
			16: v = 22'sd3;
			17: v = 22'sd1;
			default: v = 22'sd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/pgpb_front.sv @@
module pgpb_front (
	input  logic [19:0]   x_pos,
	input  logic [19:0]   y_pos,
	input  logic [17:0]   point_index,
	output pgpb_pkg::pt_t pt
);

	logic signed [19:0] xs;
	logic signed [19:0] ys;
	logic signed [39:0] xx;
	logic signed [39:0] yy;

	assign xs = $signed(x_pos);
	assign ys = $signed(y_pos);
	assign xx = 40'(xs) * 40'(xs);
	assign yy = 40'(ys) * 40'(ys);

	always_comb begin
		pt.x    = 21'(xs);
		pt.y    = 21'(ys);
		pt.axis = 1'b0;
		pt.base = 21'sd0;
		pt.r2   = $unsigned(xx) + $unsigned(yy);
		pt.tag  = point_index;
		if (ys == 20'sd0) begin
			pt.axis = 1'b1;
			pt.base = (xs >= 20'sd0) ? 21'sd0 : 21'sd524288;
		end else if (xs == 20'sd0) begin
			pt.axis = 1'b1;
			pt.base = (ys > 20'sd0) ? 21'sd262144 : -21'sd262144;
		end else if (xs < 20'sd0) begin
			pt.base = (ys >= 20'sd0) ? 21'sd524288 : -21'sd524288;
			pt.x    = -21'(xs);
			pt.y    = -21'(ys);
		end
	end

endmodule

@@ sv/pgpb_fifo.sv @@
module pgpb_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pgpb_pkg::pt_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output pgpb_pkg::pt_t rdata
);

	pgpb_pkg::pt_t mem_q [pgpb_pkg::FIFO_DEPTH];
	logic [$clog2(pgpb_pkg::FIFO_DEPTH)-1:0] wptr_q;
	logic [$clog2(pgpb_pkg::FIFO_DEPTH)-1:0] rptr_q;
	logic [$clog2(pgpb_pkg::FIFO_DEPTH):0]   cnt_q;

	assign full  = (cnt_q == ($clog2(pgpb_pkg::FIFO_DEPTH) + 1)'(pgpb_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/pgpb_back.sv @@
module pgpb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pgpb_pkg::cfg_t cfg,
	input  pgpb_pkg::pt_t  head,
	input  logic           head_vld,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     sector_index,
	output logic [7:0]     ring_index,
	output logic [17:0]    point_tag,
	output logic           kept
);

	localparam int NS = pgpb_pkg::NUM_STAGES;

	function automatic pgpb_pkg::st_t init_st(input pgpb_pkg::pt_t p);
		pgpb_pkg::st_t o;
		o      = '0;
		o.x    = 34'(p.x) <<< 10;
		o.y    = 34'(p.y) <<< 10;
		o.base = p.base;
		o.axis = p.axis;
		o.n    = p.r2;
		o.tag  = p.tag;
		return o;
	endfunction

	function automatic pgpb_pkg::st_t step(input pgpb_pkg::st_t s, input int k,
		input logic [8:0] sl, input logic [15:0] sp);
		pgpb_pkg::st_t      o;
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		logic signed [22:0] t;
		logic [20:0]        a;
		logic [29:0]        prod;
		logic [39:0]        bit_v;
		logic [16:0]        rem_w;
		o = s;
		if (k < pgpb_pkg::CORDIC_STEPS) begin
			xs = s.x >>> k;
			ys = s.y >>> k;
			if (s.y >= 34'sd0) begin
				o.x = s.x + ys;
				o.y = s.y - xs;
				o.z = s.z + pgpb_pkg::atan_entry(k);
			end else begin
				o.x = s.x - ys;
				o.y = s.y + xs;
				o.z = s.z - pgpb_pkg::atan_entry(k);
			end
		end
		if (k == pgpb_pkg::SECTOR_STAGE) begin
			t = 23'(s.base) + (s.axis ? 23'sd0 : 23'(s.z)) + 23'sd524288;
			if (t < 23'sd0) begin
				a = '0;
			end else if (t > 23'sd1048576) begin
				a = 21'd1048576;
			end else begin
				a = t[20:0];
			end
			prod  = 30'(a) * 30'(sl);
			o.sec = prod[28:20];
		end
		if (k < pgpb_pkg::SQRT_STEPS) begin
			bit_v = 40'd1 << (38 - 2 * k);
			if (s.n >= s.r + bit_v) begin
				o.n = s.n - (s.r + bit_v);
				o.r = (s.r >> 1) + bit_v;
			end else begin
				o.r = s.r >> 1;
			end
		end else begin
			rem_w = {s.rem, s.r[pgpb_pkg::SQRT_STEPS - 1 - (k - pgpb_pkg::SQRT_STEPS)]};
			if (rem_w >= {1'b0, sp}) begin
				o.rem = 16'(rem_w - {1'b0, sp});
				o.q   = {s.q[18:0], 1'b1};
			end else begin
				o.rem = rem_w[15:0];
				o.q   = {s.q[18:0], 1'b0};
			end
		end
		return o;
	endfunction

	pgpb_pkg::st_t p_q [NS];
	pgpb_pkg::st_t nxt [NS];
	logic [NS-1:0] vld_q;
	logic          adv;
	logic [8:0]    sl;
	logic [8:0]    nr;
	logic          keep;
	pgpb_pkg::st_t last;

	assign sl = (cfg.num_sectors > 9'(pgpb_pkg::MAX_SECTORS)) ? 9'(pgpb_pkg::MAX_SECTORS) :
		((cfg.num_sectors == 9'd0) ? 9'd1 : cfg.num_sectors);
	assign nr = (cfg.num_rings > 9'(pgpb_pkg::MAX_RINGS)) ? 9'(pgpb_pkg::MAX_RINGS) :
		cfg.num_rings;

	assign adv = !out_valid || out_ready;
	assign pop = adv && head_vld;

	generate
		for (genvar k = 0; k < NS; k++) begin : g_stage
			if (k == 0) begin : g_first
				always_comb nxt[k] = step(init_st(head), k, sl, cfg.ring_spacing);
			end else begin : g_rest
				always_comb nxt[k] = step(p_q[k-1], k, sl, cfg.ring_spacing);
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					p_q[k] <= nxt[k];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], head_vld};
		end
	end

	assign last = p_q[NS-1];
	assign keep = (cfg.ring_spacing != 16'd0) && (nr != 9'd0) &&
		(last.q < 20'(nr - 9'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_index <= (keep && (last.sec < sl)) ? last.sec[7:0] : 8'd0;
			ring_index   <= keep ? last.q[7:0] : 8'd0;
			point_tag    <= last.tag;
			kept         <= keep;
		end
	end

endmodule

@@ sv/polar_grid_point_binning_unit.sv @@
// From input transfer until out_valid rises, a point passes the queue, the 40 stages
// and the output register.
// Throughput: one point per cycle, set by the fully pipelined CORDIC, square root
// and divider stages; the whole back pipeline holds while the output waits.
// Reset: arst_n clears queue and pipeline valid state and loads the register
// defaults (36 sectors, 10 rings, spacing 2048).
module polar_grid_point_binning_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] x_pos,
	input  logic [19:0] y_pos,
	input  logic [17:0] point_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  sector_index,
	output logic [7:0]  ring_index,
	output logic [17:0] point_tag,
	output logic        kept,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);

	pgpb_pkg::cfg_t cfg_q;
	pgpb_pkg::pt_t  pt;
	pgpb_pkg::pt_t  head;
	logic           full;
	logic           empty;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_sectors  <= 9'd36;
			cfg_q.num_rings    <= 9'd10;
			cfg_q.ring_spacing <= 16'd2048;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pgpb_pkg::REG_NUM_SECTORS:  cfg_q.num_sectors  <= cfg_wdata[8:0];
				pgpb_pkg::REG_NUM_RINGS:    cfg_q.num_rings    <= cfg_wdata[8:0];
				pgpb_pkg::REG_RING_SPACING: cfg_q.ring_spacing <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_ready = !full;

	pgpb_front u_front (
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.point_index (point_index),
		.pt          (pt)
	);

	pgpb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && !full),
		.wdata  (pt),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head)
	);

	pgpb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.head_vld     (!empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sector_index (sector_index),
		.ring_index   (ring_index),
		.point_tag    (point_tag),
		.kept         (kept)
	);

endmodule
